// ----- rtl/clt_pkg.sv -----
// Shared types, character codes and the per-pass lookup function for the command line tokenizer.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`timescale 1ns / 1ps

package clt_pkg;

    // Parser states, one-hot
    typedef enum logic [7:0] {
        ST_SEEK     = 8'b0000_0001,
        ST_ESC      = 8'b0000_0010,
        ST_TOKEN    = 8'b0000_0100,
        ST_COMMENT  = 8'b0000_1000,
        ST_SEEK_EOL = 8'b0001_0000,
        ST_QUOTED   = 8'b0010_0000,
        ST_QESC     = 8'b0100_0000,
        ST_QEND     = 8'b1000_0000
    } t_pstate;

    // Action flags of a table entry
    localparam logic [2:0] FL_TS = 3'h1;
    localparam logic [2:0] FL_TE = 3'h2;
    localparam logic [2:0] FL_LE = 3'h4;

    // Characters with a fixed meaning
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    // Configuration register indexes
    localparam logic [1:0] REG_LESC       = 2'd0;
    localparam logic [1:0] REG_QESC       = 2'd1;
    localparam logic [1:0] REG_TOKEN_ONLY = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] LESC_RESET = 8'd92;
    localparam logic [7:0] QESC_RESET = 8'd92;

    typedef struct packed {
        logic [7:0] lesc;
        logic [7:0] qesc;
        logic       tok_only;
    } t_cfg;

    // Outcome of one table pass
    typedef struct packed {
        t_pstate    st;
        t_pstate    prev;
        logic       ftp;
        logic [2:0] flags;
        logic       ev;
    } t_pass;

    // One result item
    typedef struct packed {
        logic [7:0] pos;
        logic       ts;
        logic       te;
        logic       le;
        logic       nf;
    } t_res;

    // Look up byte c in the entry list of state st and apply the action
    function automatic t_pass step_pass(input t_pstate st, input t_pstate prev,
                                        input logic ftp, input logic [7:0] c,
                                        input t_cfg cfg);
        t_pass      p;
        logic [2:0] f;
        t_pstate    nx;
        logic       go_prev;
        logic       lesc_hit;
        logic       qesc_hit;
        logic       is_ws;
        logic       is_eos;
        logic       stop;
        lesc_hit = (cfg.lesc == 8'h00) || (c == cfg.lesc);
        qesc_hit = (cfg.qesc == 8'h00) || (c == cfg.qesc);
        is_ws    = (c == CH_SPACE) || (c == CH_TAB);
        is_eos   = (c == CH_SEMI) || (c == CH_NL);
        f        = 3'h0;
        nx       = ST_SEEK;
        go_prev  = 1'b0;

        // First matching entry in list order wins
        case (st)
            ST_SEEK: begin
                if (is_ws || is_eos) begin
                    nx = ST_SEEK;
                end else if (lesc_hit) begin
                    nx = ST_ESC;
                end else if (c == CH_HASH) begin
                    nx = ST_COMMENT;
                end else if (c == CH_QUOTE) begin
                    f  = FL_TS;
                    nx = ST_QUOTED;
                end else begin
                    f  = FL_TS;
                    nx = ST_TOKEN;
                end
            end
            ST_ESC: begin
                go_prev = 1'b1;
            end
            ST_TOKEN: begin
                if (is_ws) begin
                    f  = FL_TE;
                    nx = ST_SEEK_EOL;
                end else if (c == CH_HASH) begin
                    f  = FL_TE | FL_LE;
                    nx = ST_COMMENT;
                end else if (is_eos) begin
                    f  = FL_TE | FL_LE;
                    nx = ST_SEEK;
                end else begin
                    nx = ST_TOKEN;
                end
            end
            ST_COMMENT: begin
                nx = (c == CH_NL) ? ST_SEEK : ST_COMMENT;
            end
            ST_SEEK_EOL: begin
                if (is_eos) begin
                    f  = FL_LE;
                    nx = ST_SEEK;
                end else if (c == CH_HASH) begin
                    f  = FL_LE;
                    nx = ST_COMMENT;
                end else if (lesc_hit) begin
                    nx = ST_ESC;
                end else if (c == CH_QUOTE) begin
                    nx = ST_QUOTED;
                end else begin
                    nx = ST_SEEK_EOL;
                end
            end
            ST_QUOTED: begin
                if (c == CH_QUOTE) begin
                    nx = ST_QEND;
                end else if (qesc_hit) begin
                    nx = ST_QESC;
                end else begin
                    nx = ST_QUOTED;
                end
            end
            ST_QESC: begin
                nx = ST_QUOTED;
            end
            ST_QEND: begin
                if (c == CH_HASH) begin
                    f  = FL_TE | FL_LE;
                    nx = ST_COMMENT;
                end else if (is_eos) begin
                    f  = FL_TE | FL_LE;
                    nx = ST_SEEK;
                end else begin
                    f  = FL_TE;
                    nx = ST_SEEK_EOL;
                end
            end
            default: begin
                nx = ST_SEEK;
            end
        endcase

        p.st    = st;
        p.prev  = prev;
        p.ftp   = ftp;
        p.flags = 3'h0;
        p.ev    = 1'b0;
        stop    = 1'b0;

        // Token flags count only for the first token of a statement
        if (ftp) begin
            if ((f & FL_TS) != 3'h0) begin
                p.flags = p.flags | FL_TS;
            end
            if ((f & FL_TE) != 3'h0) begin
                p.flags = p.flags | FL_TE;
                if (cfg.tok_only) begin
                    p.ev = 1'b1;
                    stop = 1'b1;
                end else begin
                    p.ftp = 1'b0;
                end
            end
        end
        if (!stop && ((f & FL_LE) != 3'h0)) begin
            p.flags = p.flags | FL_LE;
            p.ev    = 1'b1;
            stop    = 1'b1;
        end
        // Advance unless an event ended the pass
        if (!stop) begin
            p.prev = st;
            p.st   = go_prev ? prev : nx;
        end
        return p;
    endfunction

endpackage

// ----- rtl/clt_cfg.sv -----
// Configuration registers of the command line tokenizer: escape characters and token-only mode.
// Depends on clt_pkg for the register indexes, reset values and the t_cfg struct.
`timescale 1ns / 1ps

module clt_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [1:0]    i_idx,
    input  logic [7:0]    i_data,
    output clt_pkg::t_cfg o_cfg
);

    clt_pkg::t_cfg r_cfg;

    // Write the addressed register; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lesc     <= clt_pkg::LESC_RESET;
            r_cfg.qesc     <= clt_pkg::QESC_RESET;
            r_cfg.tok_only <= 1'b0;
        end else if (i_we) begin
            case (i_idx)
                clt_pkg::REG_LESC:       r_cfg.lesc     <= i_data;
                clt_pkg::REG_QESC:       r_cfg.qesc     <= i_data;
                clt_pkg::REG_TOKEN_ONLY: r_cfg.tok_only <= i_data[0];
                default:                 r_cfg          <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/clt_parse.sv -----
// Input register and parser state of the command line tokenizer; forms one result per byte.
// Depends on clt_pkg for the state type, the pass function and the result struct.
`timescale 1ns / 1ps

module clt_parse #(
    parameter int unsigned BUFFER_BYTES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  clt_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    output logic          o_ready,
    output logic          o_valid,
    output clt_pkg::t_res o_res,
    input  logic          i_adv
);

    localparam int unsigned PosTopInt = (BUFFER_BYTES - 1 > 255) ? 255 : BUFFER_BYTES - 1;
    localparam logic [7:0]  PosTop    = 8'(PosTopInt);

    logic              r_v1;
    logic [7:0]        r_char;
    logic              r_last;
    clt_pkg::t_pstate  r_st;
    clt_pkg::t_pstate  r_prev;
    logic              r_ftp;
    logic              r_evs;
    logic [7:0]        r_pos;

    clt_pkg::t_pstate  n_st;
    clt_pkg::t_pstate  n_prev;
    logic              n_ftp;
    logic              n_evs;
    logic [7:0]        n_pos;

    clt_pkg::t_pass    w_p1;
    clt_pkg::t_pass    w_p2;
    logic [2:0]        w_flags;
    logic              w_move;

    assign o_ready = !r_v1 || i_adv;
    assign o_valid = r_v1;
    assign w_move  = r_v1 && i_adv;

    // Run the byte once, and again from seek after an event
    always_comb begin
        w_p1 = clt_pkg::step_pass(r_st, r_prev, r_ftp, r_char, i_cfg);
        w_p2 = clt_pkg::step_pass(clt_pkg::ST_SEEK, clt_pkg::ST_SEEK, 1'b1, r_char, i_cfg);
        if (w_p1.ev) begin
            n_st    = w_p2.st;
            n_prev  = w_p2.prev;
            n_ftp   = w_p2.ftp;
            n_evs   = 1'b1;
            w_flags = w_p1.flags | w_p2.flags;
        end else begin
            n_st    = w_p1.st;
            n_prev  = w_p1.prev;
            n_ftp   = w_p1.ftp;
            n_evs   = r_evs;
            w_flags = w_p1.flags;
        end
        n_pos = (r_pos < PosTop) ? r_pos + 8'd1 : r_pos;

        o_res.pos = r_pos;
        o_res.ts  = (w_flags & clt_pkg::FL_TS) != 3'h0;
        o_res.te  = (w_flags & clt_pkg::FL_TE) != 3'h0;
        o_res.le  = (w_flags & clt_pkg::FL_LE) != 3'h0;
        o_res.nf  = r_last && !n_evs;

        // Return to the reset state after the final byte of a buffer
        if (r_last) begin
            n_st   = clt_pkg::ST_SEEK;
            n_prev = clt_pkg::ST_SEEK;
            n_ftp  = 1'b1;
            n_evs  = 1'b0;
            n_pos  = 8'd0;
        end
    end

    // Hold the incoming item until the result stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char;
            r_last <= i_last;
        end
    end

    // Advance parser state as each result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= clt_pkg::ST_SEEK;
            r_prev <= clt_pkg::ST_SEEK;
            r_ftp  <= 1'b1;
            r_evs  <= 1'b0;
            r_pos  <= 8'd0;
        end else if (w_move) begin
            r_st   <= n_st;
            r_prev <= n_prev;
            r_ftp  <= n_ftp;
            r_evs  <= n_evs;
            r_pos  <= n_pos;
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_last) |=> (r_st == clt_pkg::ST_SEEK && r_pos == 8'd0 && r_ftp && !r_evs))
        else $error("parser state not cleared after final byte");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && !r_last && r_pos < PosTop) |=> (r_pos == $past(r_pos) + 8'd1))
        else $error("byte position did not advance");
`endif

endmodule

// ----- rtl/command_line_tokenizer.sv -----
// Top level of the command line tokenizer: configuration port, parser stage and result register.
// Depends on clt_pkg, clt_cfg and clt_parse.
//
//  port group    dir  tdata          tuser / other
//  s_axis_*      in   char_in[7:0]   tlast = last_char
//  m_axis_*      out  position[7:0]  tuser = {not_found, statement_end, token_end, token_start}
//  i_cfg_*       in   write data     index 0 line escape, 1 quote escape, 2 token-only mode
//
// One byte per cycle sustained while m_axis_tready stays high; an accepted byte passes the input
// register, then the result register. The table lookup and the restart pass from seek
// are one combinational step between the two registers.
// Reset (i_rst_n low, synchronous) empties both stages and returns the parser to seek.
// A stalled result holds in the output register while one further byte waits in the input stage.
`timescale 1ns / 1ps

module command_line_tokenizer #(
    parameter int unsigned BUFFER_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] char_position
    output logic [3:0] m_axis_tuser    // [0] token_start [1] token_end [2] statement_end [3] not_found
);

    clt_pkg::t_cfg w_cfg;
    clt_pkg::t_res w_res;
    logic          w_pv;
    logic          w_adv;

    logic          r_ov;
    clt_pkg::t_res r_res;

    clt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    clt_parse #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_ready (s_axis_tready),
        .o_valid (w_pv),
        .o_res   (w_res),
        .i_adv   (w_adv)
    );

    // Load the result register when it is empty or being drained
    assign w_adv = !r_ov || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= w_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_pv) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_res.pos;
    assign m_axis_tuser  = {r_res.nf, r_res.le, r_res.te, r_res.ts};

`ifndef SYNTHESIS
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> w_pv)
        else $error("accepted item missing from input stage");

    a_res_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pv && w_adv) |=> r_ov)
        else $error("result lost between stages");
`endif

endmodule

// ----- tb/command_line_tokenizer_tb.sv -----
// Self-checking testbench for command_line_tokenizer: streams command text one byte per item
// and checks each result against a tokenizer state machine kept in the testbench.
// Depends on clt_pkg and rtl/command_line_tokenizer.sv.
`timescale 1ns / 1ps

module command_line_tokenizer_tb;

    localparam int unsigned BUFFER_BYTES = 256;
    localparam logic [7:0]  POS_TOP      = (BUFFER_BYTES - 1 > 255) ? 8'd255 : 8'(BUFFER_BYTES - 1);
    localparam logic [1:0]  REG_SPARE    = 2'd3;  // no register here, writes are dropped
    localparam logic [7:0]  CH_BSLASH    = 8'h5C;
    localparam int          DRAIN_CYCLES = 6;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char_item;

    typedef struct packed {
        logic [7:0] pos;
        logic       tok_start;
        logic       tok_end;
        logic       stmt_end;
        logic       not_found;
    } t_marks;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic [1:0] i_cfg_idx     = '0;
    logic [7:0] i_cfg_data    = '0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;   // [7:0] char_in
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;         // [7:0] char_position
    logic [3:0] m_axis_tuser;         // [0] token_start [1] token_end [2] statement_end [3] not_found

    command_line_tokenizer #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    t_char_item char_queue[$];
    t_marks     expected_marks[$];
    t_char_item next_char;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         mismatch_count;

    // Tokenizer copy: configuration and parser state
    logic [7:0]        cfg_lesc;
    logic [7:0]        cfg_qesc;
    logic              cfg_tok_only;
    clt_pkg::t_pstate  tok_state;
    clt_pkg::t_pstate  tok_prev;
    logic              first_pending;
    logic              event_seen;
    logic [7:0]        position;

    function automatic void clear_parser();
        tok_state     = clt_pkg::ST_SEEK;
        tok_prev      = clt_pkg::ST_SEEK;
        first_pending = 1'b1;
        event_seen    = 1'b0;
        position      = '0;
    endfunction

    // One walk through the entry list of the current state; first hit wins
    function automatic logic [2:0] table_pass(input logic [7:0] c, output logic ev);
        logic [2:0]       f;
        logic [2:0]       out;
        clt_pkg::t_pstate nx;
        logic             back;
        logic             lesc_hit;
        logic             qesc_hit;
        logic             is_ws;
        logic             is_eos;
        lesc_hit = (cfg_lesc == 8'h00) || (c == cfg_lesc);
        qesc_hit = (cfg_qesc == 8'h00) || (c == cfg_qesc);
        is_ws    = (c == clt_pkg::CH_SPACE) || (c == clt_pkg::CH_TAB);
        is_eos   = (c == clt_pkg::CH_SEMI) || (c == clt_pkg::CH_NL);
        f        = '0;
        nx       = clt_pkg::ST_SEEK;
        back     = 1'b0;
        ev       = 1'b0;
        out      = '0;
        case (tok_state)
            clt_pkg::ST_SEEK: begin
                if (is_ws || is_eos) begin
                    nx = clt_pkg::ST_SEEK;
                end else if (lesc_hit) begin
                    nx = clt_pkg::ST_ESC;
                end else if (c == clt_pkg::CH_HASH) begin
                    nx = clt_pkg::ST_COMMENT;
                end else if (c == clt_pkg::CH_QUOTE) begin
                    f  = clt_pkg::FL_TS;
                    nx = clt_pkg::ST_QUOTED;
                end else begin
                    f  = clt_pkg::FL_TS;
                    nx = clt_pkg::ST_TOKEN;
                end
            end
            clt_pkg::ST_ESC: begin
                back = 1'b1;
            end
            clt_pkg::ST_TOKEN: begin
                if (is_ws) begin
                    f  = clt_pkg::FL_TE;
                    nx = clt_pkg::ST_SEEK_EOL;
                end else if (c == clt_pkg::CH_HASH) begin
                    f  = clt_pkg::FL_TE | clt_pkg::FL_LE;
                    nx = clt_pkg::ST_COMMENT;
                end else if (is_eos) begin
                    f  = clt_pkg::FL_TE | clt_pkg::FL_LE;
                    nx = clt_pkg::ST_SEEK;
                end else begin
                    nx = clt_pkg::ST_TOKEN;
                end
            end
            clt_pkg::ST_COMMENT: begin
                nx = (c == clt_pkg::CH_NL) ? clt_pkg::ST_SEEK : clt_pkg::ST_COMMENT;
            end
            clt_pkg::ST_SEEK_EOL: begin
                if (is_eos) begin
                    f  = clt_pkg::FL_LE;
                    nx = clt_pkg::ST_SEEK;
                end else if (c == clt_pkg::CH_HASH) begin
                    f  = clt_pkg::FL_LE;
                    nx = clt_pkg::ST_COMMENT;
                end else if (lesc_hit) begin
                    nx = clt_pkg::ST_ESC;
                end else if (c == clt_pkg::CH_QUOTE) begin
                    nx = clt_pkg::ST_QUOTED;
                end else begin
                    nx = clt_pkg::ST_SEEK_EOL;
                end
            end
            clt_pkg::ST_QUOTED: begin
                if (c == clt_pkg::CH_QUOTE) begin
                    nx = clt_pkg::ST_QEND;
                end else if (qesc_hit) begin
                    nx = clt_pkg::ST_QESC;
                end else begin
                    nx = clt_pkg::ST_QUOTED;
                end
            end
            clt_pkg::ST_QESC: begin
                nx = clt_pkg::ST_QUOTED;
            end
            default: begin
                if (c == clt_pkg::CH_HASH) begin
                    f  = clt_pkg::FL_TE | clt_pkg::FL_LE;
                    nx = clt_pkg::ST_COMMENT;
                end else if (is_eos) begin
                    f  = clt_pkg::FL_TE | clt_pkg::FL_LE;
                    nx = clt_pkg::ST_SEEK;
                end else begin
                    f  = clt_pkg::FL_TE;
                    nx = clt_pkg::ST_SEEK_EOL;
                end
            end
        endcase

        // Token marks count only for the first token of a statement
        if (first_pending) begin
            if ((f & clt_pkg::FL_TS) != '0) begin
                out = out | clt_pkg::FL_TS;
            end
            if ((f & clt_pkg::FL_TE) != '0) begin
                out = out | clt_pkg::FL_TE;
                if (cfg_tok_only) begin
                    ev = 1'b1;
                    return out;
                end
                first_pending = 1'b0;
            end
        end
        if ((f & clt_pkg::FL_LE) != '0) begin
            out = out | clt_pkg::FL_LE;
            ev  = 1'b1;
            return out;
        end
        if (back) begin
            nx = tok_prev;
        end
        tok_prev  = tok_state;
        tok_state = nx;
        return out;
    endfunction

    // Marks for one byte: an event restarts from seek and runs the byte again
    function automatic t_marks tokenize_char(input logic [7:0] c, input logic last);
        t_marks     r;
        logic [2:0] fl;
        logic       ev;
        logic       ev2;
        r.pos = position;
        if (position < POS_TOP) begin
            position = position + 8'd1;
        end
        fl = table_pass(c, ev);
        if (ev) begin
            event_seen    = 1'b1;
            tok_state     = clt_pkg::ST_SEEK;
            tok_prev      = clt_pkg::ST_SEEK;
            first_pending = 1'b1;
            fl            = fl | table_pass(c, ev2);
            if (ev2) begin
                event_seen = 1'b1;
            end
        end
        r.tok_start = (fl & clt_pkg::FL_TS) != '0;
        r.tok_end   = (fl & clt_pkg::FL_TE) != '0;
        r.stmt_end  = (fl & clt_pkg::FL_LE) != '0;
        r.not_found = last && !event_seen;
        if (last) begin
            clear_parser();
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Driver: predict the item taken at this edge, then present the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_marks.push_back(tokenize_char(s_axis_tdata, s_axis_tlast));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (char_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_char = char_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_char.code;
                    s_axis_tlast  <= next_char.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest expectation, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_marks.size() == 0) begin
                    report_mismatch("result with nothing expected, position", m_axis_tdata,
                                    8'd0);
                end else begin
                    t_marks want;
                    want = expected_marks.pop_front();
                    if (m_axis_tdata !== want.pos)
                        report_mismatch("char_position", m_axis_tdata, want.pos);
                    if (m_axis_tuser[0] !== want.tok_start)
                        report_mismatch("token_start", 8'(m_axis_tuser[0]),
                                        8'(want.tok_start));
                    if (m_axis_tuser[1] !== want.tok_end)
                        report_mismatch("token_end", 8'(m_axis_tuser[1]), 8'(want.tok_end));
                    if (m_axis_tuser[2] !== want.stmt_end)
                        report_mismatch("statement_end", 8'(m_axis_tuser[2]),
                                        8'(want.stmt_end));
                    if (m_axis_tuser[3] !== want.not_found)
                        report_mismatch("not_found", 8'(m_axis_tuser[3]),
                                        8'(want.not_found));
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Stimulus helpers
    task automatic push_ch(input logic [7:0] c);
        t_char_item it;
        it.code = c;
        it.last = 1'b0;
        char_queue.push_back(it);
    endtask

    // Mark the newest pending byte as the end of its buffer
    task automatic end_buffer();
        t_char_item it;
        it      = char_queue.pop_back();
        it.last = 1'b1;
        char_queue.push_back(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_ch(s[i]);
        end
        end_buffer();
    endtask

    function automatic logic [7:0] pick_letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? clt_pkg::CH_SPACE : clt_pkg::CH_TAB;
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0: return clt_pkg::CH_SPACE;
            1: return clt_pkg::CH_TAB;
            2: return clt_pkg::CH_SEMI;
            3: return clt_pkg::CH_NL;
            4: return clt_pkg::CH_HASH;
            5: return clt_pkg::CH_QUOTE;
            6: return cfg_lesc;
            7: return cfg_qesc;
            8: return pick_letter();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_escape();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return CH_BSLASH;
            3: return clt_pkg::CH_HASH;
            4: return clt_pkg::CH_QUOTE;
            5: return clt_pkg::CH_SEMI;
            6: return clt_pkg::CH_SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_word();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 5))
                0: push_ch(8'($urandom_range(0, 255)));
                1: begin
                    push_ch(cfg_lesc);
                    push_ch(pick_char());
                end
                default: push_ch(pick_letter());
            endcase
        end
    endtask

    task automatic push_quoted();
        push_ch(clt_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) begin
                push_ch(cfg_qesc);
                push_ch(pick_char());
            end else begin
                push_ch(pick_letter());
            end
        end
        if ($urandom_range(0, 7) != 0) begin
            push_ch(clt_pkg::CH_QUOTE);
        end
    endtask

    // One statement: optional blanks, command, arguments, optional terminator
    task automatic push_statement();
        repeat ($urandom_range(0, 2)) push_ch(pick_blank());
        if ($urandom_range(0, 3) == 0) push_quoted(); else push_word();
        repeat ($urandom_range(0, 3)) begin
            push_ch(pick_blank());
            if ($urandom_range(0, 3) == 0) push_quoted(); else push_word();
        end
        case ($urandom_range(0, 4))
            0: push_ch(clt_pkg::CH_SEMI);
            1: push_ch(clt_pkg::CH_NL);
            2: begin
                push_ch(pick_blank());
                push_ch(clt_pkg::CH_HASH);
                push_word();
                push_ch(clt_pkg::CH_NL);
            end
            3: push_ch(clt_pkg::CH_HASH);
            default: ;
        endcase
    endtask

    // Fill a phase: mostly well-formed lines, some raw noise
    task automatic fill_random(input int n_items);
        while (char_queue.size() < n_items) begin
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 4)) push_statement();
            end else begin
                repeat ($urandom_range(1, 24)) push_ch(pick_char());
            end
            end_buffer();
        end
    endtask

    // Hold off until every item has gone through and the block is quiet
    task automatic wait_drained();
        while (char_queue.size() != 0 || s_axis_tvalid || expected_marks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            clt_pkg::REG_LESC:       cfg_lesc = val;
            clt_pkg::REG_QESC:       cfg_qesc = val;
            clt_pkg::REG_TOKEN_ONLY: cfg_tok_only = val[0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [7:0] lesc, input logic [7:0] qesc, input logic tok,
                             input int s_pct, input int r_pct, input int n_items);
        wait_drained();
        write_reg(clt_pkg::REG_LESC, lesc);
        write_reg(clt_pkg::REG_QESC, qesc);
        write_reg(clt_pkg::REG_TOKEN_ONLY, {7'd0, tok});
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        fill_random(n_items);
    endtask

    initial begin
        cfg_lesc       = clt_pkg::LESC_RESET;
        cfg_qesc       = clt_pkg::QESC_RESET;
        cfg_tok_only   = 1'b0;
        send_idle_pct  = 21;
        recv_idle_pct  = 82;
        mismatch_count = 0;
        clear_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, NUL and 0xFF bytes, escapes, quotes, comments, lone byte
        push_ch(8'h00);
        end_buffer();
        push_text("\\#a b\"q\\\"\"#z\n");
        push_text("\"x\";");
        push_ch(8'hFF);
        end_buffer();
        push_text("a;");

        // Defaults written back, spare index poked, one buffer long enough to saturate
        wait_drained();
        write_reg(REG_SPARE, 8'hA5);
        write_reg(clt_pkg::REG_LESC, clt_pkg::LESC_RESET);
        write_reg(clt_pkg::REG_QESC, clt_pkg::QESC_RESET);
        write_reg(clt_pkg::REG_TOKEN_ONLY, 8'd0);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        while (char_queue.size() < 280) push_statement();
        end_buffer();
        fill_random(300);

        run_phase(8'h00, 8'h00, 1'b1, 21, 82, 100);
        run_phase(8'hFF, 8'hFF, 1'b0, 82, 21, 100);
        run_phase(pick_escape(), pick_escape(), 1'b1, 82, 21, 100);
        run_phase(pick_escape(), pick_escape(), 1'b0, 0, 0, 100);
        run_phase(8'h00, CH_BSLASH, 1'b0, 0, 0, 90);
        run_phase(CH_BSLASH, 8'h00, 1'b1, 0, 0, 90);

        wait_drained();
        if (mismatch_count == 0 && expected_marks.size() == 0) begin
            $display("command_line_tokenizer: match");
        end else begin
            $display("command_line_tokenizer: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("command_line_tokenizer: mismatch");
        $finish;
    end

endmodule
